>>> rtl/rwlp_pkg.sv
// Shared types and constants for the register write list packer.
// No dependencies; imported by every module of the block.
package rwlp_pkg;

  typedef logic [7:0] byte_t;

  // Default depth of the command list store
  localparam int unsigned ListDepthDef = 128;

  // Packing mode codes (code 3 is ignored)
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_SUCC    = 2'd1;
  localparam logic [1:0] MODE_BURST   = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  // Input op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_TAG_NORMAL = 2'd0;
  localparam logic [1:0] CFG_TAG_SUCC   = 2'd1;
  localparam logic [1:0] CFG_TAG_BURST  = 2'd2;

  // Reset values of the header tags
  localparam byte_t TAG_NORMAL_RST = 8'h00;
  localparam byte_t TAG_SUCC_RST   = 8'h40;
  localparam byte_t TAG_BURST_RST  = 8'h80;

  // Bank-select register high byte, header match mask, no-bank marker
  localparam byte_t      BANK_HI  = 8'h2F;
  localparam logic [5:0] HDR_MASK = 6'h3F;
  localparam byte_t      NO_BANK  = 8'hFF;

endpackage

>>> rtl/register_write_list_packer.sv
// Top level of the register write list packer: input buffer, packing sequencer,
// output register. Depends on rwlp_pkg and instantiates rwlp_store.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one register write (op 0) or
//   one flush command (op 1). Output channel (out_valid_o/out_ready_i) carries
//   list byte writes (kind 0) and flush requests (kind 1); last_o marks the
//   final result of each input. The cfg port writes the three header tags on
//   each edge with cfg_we_i high; the user must write them only while the block
//   is idle, since the block itself does not enforce this.
//   Flow: the input buffer registers an item; for a write the sequencer runs
//   start, the group lookup reads when the open group must be looked up,
//   the room check, a flush if the list is full, and emit. One result per
//   cycle while emitting, unless the receiver stalls; a bank change runs two
//   packing passes. The group lookup reads header, count and address bytes
//   one after another through the single read port of the list store.
//   A one-entry input buffer takes the next item while the current one works.
//   Reset: list count 0, group start 1, previous mode normal, no bank selected,
//   tags at defaults. Store contents are undefined until written.
//   Receiver stall: the output register holds its result and the sequencer
//   waits; nothing is dropped.
module register_write_list_packer #(
  parameter int unsigned LIST_DEPTH = rwlp_pkg::ListDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  rwlp_pkg::byte_t cfg_wdata_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            op_i,
  input  logic [15:0]     reg_addr_i,
  input  rwlp_pkg::byte_t value_i,
  input  logic [1:0]      mode_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            kind_o,
  output rwlp_pkg::byte_t index_o,
  output rwlp_pkg::byte_t data_o,
  output logic            last_o
);
  import rwlp_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_RD1, S_RD2, S_RD3, S_PLAN, S_FLUSH, S_EMIT
  } state_e;

  // configuration
  byte_t tag_norm_q, tag_succ_q, tag_burst_q;

  // input buffer
  logic        buf_valid_q;
  logic        buf_op_q;
  logic [15:0] buf_addr_q;
  byte_t       buf_val_q;
  logic [1:0]  buf_mode_q;

  // packing state
  state_e      state_q;
  byte_t       fill_q, gs_q, last_bank_q, cnt_q;
  logic [1:0]  prev_mode_q, job_mode_q, beat_q;
  byte_t       job_hi_q, job_lo_q, job_val_q, pend_lo_q, pend_val_q;
  logic        pend_q, fresh_q, flush_only_q;

  // output register
  logic        out_valid_q, out_kind_q, out_last_q;
  byte_t       out_idx_q, out_data_q;

  // sequencer datapath
  logic        need_lookup, rd_en, can_load, emit_req, emit_fire, emit_last;
  logic        emit_kind, last_beat, mem_we, is_succ, is_norm, overflow;
  byte_t       rd_addr, rd_data, gs_eff, emit_idx, emit_data, tag_sel, bank;
  logic [2:0]  size;
  logic [8:0]  fill_sum;

  assign is_norm     = (job_mode_q == MODE_NORMAL);
  assign is_succ     = (job_mode_q == MODE_SUCC);
  assign need_lookup = (prev_mode_q == job_mode_q) && (fill_q != 8'd0) && !is_norm;
  assign gs_eff      = fresh_q ? fill_q + 8'd1 : gs_q;
  assign tag_sel     = is_norm ? tag_norm_q : (is_succ ? tag_succ_q : tag_burst_q);
  assign size        = is_norm ? 3'd3 : (fresh_q ? 3'd4 : (is_succ ? 3'd2 : 3'd1));
  assign fill_sum    = {1'b0, fill_q} + {6'b0, size};
  assign overflow    = fill_sum >= 9'(LIST_DEPTH);
  assign last_beat   = is_norm ? (beat_q == 2'd2) : (beat_q == 2'd3);
  assign can_load    = !out_valid_q || out_ready_i;
  assign emit_fire   = emit_req && can_load;
  assign mem_we      = emit_fire && (emit_kind == KIND_WRITE);
  assign bank        = {1'b0, buf_addr_q[14:8]};

  // read address, result selection
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = gs_q;
    emit_req  = 1'b0;
    emit_kind = KIND_WRITE;
    emit_idx  = fill_q;
    emit_data = 8'd0;
    emit_last = 1'b0;
    case (state_q)
      S_START: begin
        rd_en   = need_lookup;
        rd_addr = gs_q - 8'd1;
      end
      S_RD1: begin
        rd_en   = 1'b1;
        rd_addr = gs_q;
      end
      S_RD2: begin
        rd_en   = (job_mode_q == MODE_BURST);
        rd_addr = gs_q + 8'd1;
      end
      S_FLUSH: begin
        emit_req  = 1'b1;
        emit_kind = KIND_FLUSH;
        emit_idx  = fill_q - 8'd1;
        emit_last = flush_only_q;
      end
      S_EMIT: begin
        emit_req  = 1'b1;
        emit_last = last_beat && !pend_q;
        if (is_norm) begin
          emit_idx = fill_q + {6'b0, beat_q};
          case (beat_q)
            2'd0:    emit_data = job_hi_q | tag_sel;
            2'd1:    emit_data = job_lo_q;
            default: emit_data = job_val_q;
          endcase
        end else begin
          case (beat_q)
            2'd0: begin
              emit_idx  = gs_eff - 8'd1;
              emit_data = job_hi_q | tag_sel;
            end
            2'd1: begin
              emit_idx  = gs_eff;
              emit_data = fresh_q ? 8'd0 : cnt_q + 8'd1;
            end
            2'd2: begin
              emit_idx  = (is_succ && !fresh_q) ? fill_q : gs_eff + 8'd1;
              emit_data = job_lo_q;
            end
            default: begin
              emit_idx  = fresh_q ? fill_q + 8'd3 : (is_succ ? fill_q + 8'd1 : fill_q);
              emit_data = job_val_q;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // sequencer, buffers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_norm_q   <= TAG_NORMAL_RST;
      tag_succ_q   <= TAG_SUCC_RST;
      tag_burst_q  <= TAG_BURST_RST;
      buf_valid_q  <= 1'b0;
      buf_op_q     <= OP_WRITE;
      buf_addr_q   <= '0;
      buf_val_q    <= '0;
      buf_mode_q   <= MODE_NORMAL;
      state_q      <= S_IDLE;
      fill_q       <= 8'd0;
      gs_q         <= 8'd1;
      last_bank_q  <= NO_BANK;
      cnt_q        <= 8'd0;
      prev_mode_q  <= MODE_NORMAL;
      job_mode_q   <= MODE_NORMAL;
      beat_q       <= 2'd0;
      job_hi_q     <= '0;
      job_lo_q     <= '0;
      job_val_q    <= '0;
      pend_lo_q    <= '0;
      pend_val_q   <= '0;
      pend_q       <= 1'b0;
      fresh_q      <= 1'b0;
      flush_only_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_WRITE;
      out_last_q   <= 1'b0;
      out_idx_q    <= '0;
      out_data_q   <= '0;
    end else begin
      // tag registers
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TAG_NORMAL: tag_norm_q  <= cfg_wdata_i;
          CFG_TAG_SUCC:   tag_succ_q  <= cfg_wdata_i;
          CFG_TAG_BURST:  tag_burst_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // input buffer fill
      if (in_valid_i && in_ready_o) begin
        buf_valid_q <= 1'b1;
        buf_op_q    <= op_i;
        buf_addr_q  <= reg_addr_i;
        buf_val_q   <= value_i;
        buf_mode_q  <= mode_i;
      end

      // output register
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= emit_kind;
        out_idx_q   <= emit_idx;
        out_data_q  <= emit_data;
        out_last_q  <= emit_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // take the buffered item: start a flush or a write, drop mode 3, and split a bank change into two passes
        S_IDLE: begin
          if (buf_valid_q) begin
            buf_valid_q <= 1'b0;
            if (buf_op_q == OP_FLUSH) begin
              if (fill_q != 8'd0) begin
                flush_only_q <= 1'b1;
                state_q      <= S_FLUSH;
              end
            end else if (buf_mode_q != MODE_IGNORED) begin
              job_mode_q   <= buf_mode_q;
              flush_only_q <= 1'b0;
              state_q      <= S_START;
              if (buf_addr_q[15] && (last_bank_q != bank)) begin
                last_bank_q <= bank;
                job_hi_q    <= BANK_HI;
                job_lo_q    <= 8'd0;
                job_val_q   <= bank;
                pend_q      <= 1'b1;
                pend_lo_q   <= buf_addr_q[7:0];
                pend_val_q  <= buf_val_q;
              end else begin
                job_hi_q  <= buf_addr_q[15] ? BANK_HI : buf_addr_q[15:8];
                job_lo_q  <= buf_addr_q[7:0];
                job_val_q <= buf_val_q;
                pend_q    <= 1'b0;
              end
            end
          end
        end
        S_START: begin
          fresh_q <= !need_lookup;
          state_q <= need_lookup ? S_RD1 : S_PLAN;
        end
        // header byte of the open group
        S_RD1: begin
          if (job_hi_q != {2'b00, rd_data[5:0] & HDR_MASK}) begin
            fresh_q <= 1'b1;
          end
          state_q <= S_RD2;
        end
        // count byte
        S_RD2: begin
          cnt_q   <= rd_data;
          state_q <= (job_mode_q == MODE_BURST) ? S_RD3 : S_PLAN;
        end
        // shared low address byte of a burst group
        S_RD3: begin
          if (rd_data != job_lo_q) begin
            fresh_q <= 1'b1;
          end
          state_q <= S_PLAN;
        end
        // room check
        S_PLAN: begin
          beat_q <= 2'd0;
          if (overflow) begin
            fresh_q <= 1'b1;
            state_q <= (fill_q != 8'd0) ? S_FLUSH : S_EMIT;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_FLUSH: begin
          if (emit_fire) begin
            fill_q  <= 8'd0;
            state_q <= flush_only_q ? S_IDLE : S_EMIT;
          end
        end
        // one list byte per transfer
        S_EMIT: begin
          if (emit_fire) begin
            beat_q <= beat_q + 2'd1;
            if (last_beat) begin
              fill_q      <= fill_sum[7:0];
              gs_q        <= gs_eff;
              prev_mode_q <= job_mode_q;
              if (pend_q) begin
                pend_q    <= 1'b0;
                job_hi_q  <= BANK_HI;
                job_lo_q  <= pend_lo_q;
                job_val_q <= pend_val_q;
                state_q   <= S_START;
              end else begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  rwlp_store #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (emit_idx[AW-1:0]),
    .wdata_i (emit_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign in_ready_o  = !buf_valid_q;
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign index_o     = out_idx_q;
  assign data_o      = out_data_q;
  assign last_o      = out_last_q;

  // list never grows past the store
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fill_q} < 9'(LIST_DEPTH))
    else $error("fill count beyond list depth");

  // the final result of an item returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && emit_last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after final result");

  // lookups happen only for grouped modes
  a_lookup_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (job_mode_q != MODE_NORMAL))
    else $error("store read in normal mode");

  // reads and writes of the store never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && mem_we))
    else $error("store read and write overlap");

endmodule

>>> rtl/rwlp_store.sv
// Command list store: one write port, one read port, registered read data.
// Depends on rwlp_pkg for the byte type.
module rwlp_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  rwlp_pkg::byte_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output rwlp_pkg::byte_t rdata_o
);
  import rwlp_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/list_packer_checker.sv
// Scoreboard for the register write list packer: mirrors the list store and
// group state, predicts list byte writes and flush requests, compares results.
// Depends on rwlp_pkg; instantiated beside the block by tb.
module list_packer_checker #(
  parameter int unsigned LIST_DEPTH = rwlp_pkg::ListDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  rwlp_pkg::byte_t cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic            op_i,
  input  logic [15:0]     reg_addr_i,
  input  rwlp_pkg::byte_t value_i,
  input  logic [1:0]      mode_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic            kind_i,
  input  rwlp_pkg::byte_t index_i,
  input  rwlp_pkg::byte_t data_i,
  input  logic            last_i,
  output int unsigned     fail_cnt_o,
  output int unsigned     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rwlp_pkg::*;

  typedef struct packed {
    logic  kind;
    byte_t index;
    byte_t data;
    logic  last;
  } list_result_t;

  // Mirrored block state
  byte_t      tag_nrm, tag_suc, tag_bst;
  byte_t      list_mem [256];
  byte_t      fill_cnt;
  byte_t      grp_start;
  logic [1:0] prev_mode;
  byte_t      cur_bank;

  list_result_t item_q[$];      // results of the item being predicted
  list_result_t expected_list_q[$];
  int unsigned  n_fail;

  task automatic emit_result(input logic k, input byte_t idx, input byte_t d);
    list_result_t r;
    r.kind  = k;
    r.index = idx;
    r.data  = d;
    r.last  = 1'b0;
    item_q.push_back(r);
  endtask

  task automatic store_byte(input byte_t idx, input byte_t d);
    list_mem[idx] = d;
    emit_result(KIND_WRITE, idx, d);
  endtask

  // Flush request only when the list holds something
  task automatic flush_list();
    if (fill_cnt != 8'd0) begin
      emit_result(KIND_FLUSH, fill_cnt - 8'd1, 8'd0);
      fill_cnt = 8'd0;
    end
  endtask

  // Pack one write (bank already resolved) in normal, successive or burst form
  task automatic pack_write(input logic [15:0] addr, input byte_t val, input logic [1:0] md);
    byte_t       hi, lo, gs, cnt, tag;
    int unsigned need;
    logic        fresh;
    hi = addr[15:8];
    lo = addr[7:0];
    fresh = (prev_mode != md) || (fill_cnt == 8'd0);
    // open group continues only if the masked header and (burst) low byte match
    if (!fresh && md != MODE_NORMAL) begin
      if (hi != (list_mem[grp_start - 8'd1] & {2'b00, HDR_MASK})) fresh = 1'b1;
      if (md == MODE_BURST && lo != list_mem[grp_start + 8'd1]) fresh = 1'b1;
    end
    if (md == MODE_NORMAL)    need = 3;
    else if (md == MODE_SUCC) need = fresh ? 4 : 2;
    else                      need = fresh ? 4 : 1;
    // would not fit: flush first and start over
    if (int'(fill_cnt) + need >= LIST_DEPTH) begin
      flush_list();
      fill_cnt = 8'd0;
      fresh = 1'b1;
    end
    if (fresh) grp_start = fill_cnt + 8'd1;
    cnt = fill_cnt;
    gs  = grp_start;

    if (md == MODE_NORMAL) begin
      prev_mode = md;
      store_byte(cnt, hi | tag_nrm);
      store_byte(cnt + 8'd1, lo);
      store_byte(cnt + 8'd2, val);
      fill_cnt = cnt + 8'd3;
    end else begin
      tag = (md == MODE_SUCC) ? tag_suc : tag_bst;
      if (fresh) begin
        prev_mode = md;
        store_byte(gs - 8'd1, hi | tag);
        store_byte(gs, 8'd0);
        if (md == MODE_SUCC) store_byte(cnt + 8'd2, lo);
        else                 store_byte(gs + 8'd1, lo);
        store_byte(cnt + 8'd3, val);
        fill_cnt = cnt + 8'd4;
      end else begin
        // rewrite header, bump shared count, append
        store_byte(gs - 8'd1, hi | tag);
        store_byte(gs, list_mem[gs] + 8'd1);
        if (md == MODE_SUCC) begin
          store_byte(cnt, lo);
          store_byte(cnt + 8'd1, val);
          fill_cnt = cnt + 8'd2;
        end else begin
          store_byte(gs + 8'd1, lo);
          store_byte(cnt, val);
          fill_cnt = cnt + 8'd1;
        end
      end
    end
  endtask

  // Expected results of one accepted input transfer
  task automatic predict_list_writes(input logic op, input logic [15:0] addr,
                                     input byte_t val, input logic [1:0] md);
    byte_t        bank;
    list_result_t r;
    item_q.delete();
    if (op == OP_FLUSH) begin
      flush_list();
    end else if (md <= MODE_BURST) begin
      if (addr[15]) begin
        // bank select goes out only on a bank change
        bank = {1'b0, addr[14:8]};
        if (cur_bank != bank) begin
          cur_bank = bank;
          pack_write({BANK_HI, 8'h00}, bank, md);
        end
        pack_write({BANK_HI, addr[7:0]}, val, md);
      end else begin
        pack_write(addr, val, md);
      end
    end
    if (item_q.size() > 0) begin
      r = item_q.pop_back();
      r.last = 1'b1;
      item_q.push_back(r);
    end
    foreach (item_q[i]) expected_list_q.push_back(item_q[i]);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Watch config, input and output channels
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t e;
    if (!rst_ni) begin
      tag_nrm   = TAG_NORMAL_RST;
      tag_suc   = TAG_SUCC_RST;
      tag_bst   = TAG_BURST_RST;
      foreach (list_mem[i]) list_mem[i] = 8'd0;
      fill_cnt  = 8'd0;
      grp_start = 8'd1;
      prev_mode = MODE_NORMAL;
      cur_bank  = NO_BANK;
      expected_list_q.delete();
      n_fail    = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TAG_NORMAL: tag_nrm = cfg_wdata_i;
          CFG_TAG_SUCC:   tag_suc = cfg_wdata_i;
          CFG_TAG_BURST:  tag_bst = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_list_writes(op_i, reg_addr_i, value_i, mode_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_list_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d index 0x%0h data 0x%0h last %0d",
                   $time, kind_i, index_i, data_i, last_i);
          n_fail++;
        end else begin
          e = expected_list_q.pop_front();
          check_field("kind", 32'(e.kind), 32'(kind_i));
          check_field("index", 32'(e.index), 32'(index_i));
          check_field("data", 32'(e.data), 32'(data_i));
          check_field("last", 32'(e.last), 32'(last_i));
        end
      end
      fail_cnt_o <= n_fail;
      pending_o  <= expected_list_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top for the register write list packer: clock, reset, config
// writes, directed and random write streams, handshake idling and verdict.
// Depends on rwlp_pkg, register_write_list_packer and list_packer_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwlp_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_idx_i    = CFG_TAG_NORMAL;
  byte_t       cfg_wdata_i  = 8'd0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        op_i         = OP_WRITE;
  logic [15:0] reg_addr_i   = 16'd0;
  byte_t       value_i      = 8'd0;
  logic [1:0]  mode_i       = MODE_NORMAL;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        kind_o;
  byte_t       index_o;
  byte_t       data_o;
  logic        last_o;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 68;
  logic        hold_req    = 1'b0;
  logic        hold_taken  = 1'b0;

  register_write_list_packer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .reg_addr_i  (reg_addr_i),
    .value_i     (value_i),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .index_o     (index_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

  list_packer_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .op_i        (op_i),
    .reg_addr_i  (reg_addr_i),
    .value_i     (value_i),
    .mode_i      (mode_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_i      (kind_o),
    .index_i     (index_o),
    .data_i      (data_o),
    .last_i      (last_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #RUN_LIMIT_NS;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one item; valid is only dropped when a gap is taken
  task automatic send_item(input logic op, input logic [15:0] addr, input byte_t val,
                           input logic [1:0] md);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    reg_addr_i <= addr;
    value_i    <= val;
    mode_i     <= md;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Wait for every expected result, then let the sequencer settle
  task automatic wait_idle();
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_tags(input byte_t t_nrm, input byte_t t_suc, input byte_t t_bst);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TAG_NORMAL;
    cfg_wdata_i <= t_nrm;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TAG_SUCC;
    cfg_wdata_i <= t_suc;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TAG_BURST;
    cfg_wdata_i <= t_bst;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly runs of same-group writes with random content, plus noise
  task automatic send_random(input int unsigned n_items);
    int unsigned sent, run_len, k;
    logic [1:0]  md;
    logic [15:0] base, addr;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(99);
      if (k < 2) begin
        send_item(OP_FLUSH, 16'($urandom), 8'($urandom), 2'($urandom));
        sent++;
      end else if (k < 5) begin
        send_item(OP_WRITE, 16'($urandom), 8'($urandom), MODE_IGNORED);
      end else begin
        md   = 2'($urandom_range(MODE_BURST));
        base = 16'($urandom);
        // favor a few banks so bank reuse is common
        if (base[15] && $urandom_range(1) == 0) base[14:8] = 7'($urandom_range(3));
        run_len = $urandom_range(1, 8);
        repeat (run_len) begin
          addr = base;
          if (md == MODE_SUCC)        addr[7:0] = 8'($urandom);
          else if (md == MODE_NORMAL) addr = 16'($urandom);
          // occasional break in the run
          if ($urandom_range(7) == 0) addr = 16'($urandom);
          send_item(OP_WRITE, addr, 8'($urandom), md);
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty flush, ignored mode, extremes, group rules, banks
    send_item(OP_FLUSH, 16'h0000, 8'h00, MODE_NORMAL);
    send_item(OP_WRITE, 16'h8500, 8'h12, MODE_IGNORED);
    send_item(OP_WRITE, 16'h0000, 8'h00, MODE_NORMAL);
    send_item(OP_WRITE, 16'h7FFF, 8'hFF, MODE_NORMAL);
    send_item(OP_WRITE, 16'hFFFF, 8'hA5, MODE_NORMAL);
    send_item(OP_WRITE, 16'h8000, 8'h5A, MODE_SUCC);
    send_item(OP_WRITE, 16'h8001, 8'h01, MODE_SUCC);
    send_item(OP_WRITE, 16'h1234, 8'h11, MODE_SUCC);
    send_item(OP_WRITE, 16'h1256, 8'h22, MODE_SUCC);
    // high byte above the header mask never matches
    send_item(OP_WRITE, 16'h5234, 8'h33, MODE_SUCC);
    send_item(OP_WRITE, 16'h5240, 8'h44, MODE_SUCC);
    send_item(OP_WRITE, 16'h0A10, 8'h01, MODE_BURST);
    send_item(OP_WRITE, 16'h0A10, 8'h02, MODE_BURST);
    send_item(OP_WRITE, 16'h0A10, 8'h03, MODE_BURST);
    send_item(OP_WRITE, 16'h0A11, 8'h04, MODE_BURST);
    send_item(OP_WRITE, 16'h8305, 8'h05, MODE_BURST);
    send_item(OP_WRITE, 16'h8305, 8'h06, MODE_BURST);
    send_item(OP_WRITE, 16'h8405, 8'h07, MODE_BURST);
    send_item(OP_FLUSH, 16'hFFFF, 8'hFF, MODE_IGNORED);
    // bank survives the flush
    send_item(OP_WRITE, 16'h8405, 8'h08, MODE_BURST);
    send_item(OP_WRITE, 16'h4000, 8'hFF, MODE_NORMAL);
    send_item(OP_FLUSH, 16'h0000, 8'h00, MODE_NORMAL);
    in_valid_i <= 1'b0;
    wait_idle();

    // Phase 1: sender mostly busy, receiver mostly stalled
    set_tags(8'hFF, 8'h00, 8'hFF);
    send_random(26);
    wait_idle();

    // Phase 2: roles swapped
    tx_idle_pct = 68;
    rx_idle_pct = 15;
    set_tags(8'($urandom), 8'($urandom), 8'($urandom));
    send_random(26);
    wait_idle();

    // Phase 3: no idling, one long receiver hold-off to back up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_tags(8'h00, 8'hFF, 8'h00);
    hold_req = 1'b1;
    send_random(26);
    wait_idle();

    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
